FILE: sv/assert_macros.svh
// assertion macros used by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock outside reset
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("property violated");

// condition must never be seen outside reset
`define ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition seen");

`endif

FILE: sv/wsts_pkg.sv
// constants and types of the weighted server task scheduler
package wsts_pkg;

  localparam int NUM_SERVERS_DEF = 16;
  localparam int TIME_BITS_DEF   = 48;

  localparam int KIND_W   = 1;
  localparam int SLOT_W   = 4;
  localparam int WEIGHT_W = 16;
  localparam int DUR_W    = 16;
  localparam int SRV_W    = 4;
  localparam int START_W  = 48;
  localparam int CFG_W    = 5;

  localparam logic [CFG_W-1:0]  CNT_RESET = 5'd16;
  localparam logic [KIND_W-1:0] KIND_LOAD = 1'b0;
  localparam logic [KIND_W-1:0] KIND_TASK = 1'b1;

  // controls from the sequencer to the compare unit
  typedef struct packed {
    logic clear;     // start of a new task
    logic elem_vld;  // one server's busy time and weight present this cycle
  } scan_ctl_t;

endpackage

FILE: sv/wsts_ram.sv
// generic single write, single read ram with registered read data
module wsts_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/wsts_scan.sv
// compare unit: one server per cycle, tracks best free server and earliest busy server
module wsts_scan #(
  parameter int IDX_W     = 4,
  parameter int TIME_BITS = 48
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  wsts_pkg::scan_ctl_t           ctl_i,
  input  logic [TIME_BITS-1:0]          t0_i,
  input  logic [IDX_W-1:0]              idx_i,
  input  logic [TIME_BITS-1:0]          busy_i,
  input  logic [wsts_pkg::WEIGHT_W-1:0] weight_i,
  output logic                          free_fnd_o,
  output logic [IDX_W-1:0]              free_idx_o,
  output logic [TIME_BITS-1:0]          min_busy_o,
  output logic [IDX_W-1:0]              min_idx_o
);
  import wsts_pkg::*;

  logic                 free_fnd_q, free_fnd_d;
  logic [IDX_W-1:0]     free_idx_q, free_idx_d;
  logic [WEIGHT_W-1:0]  free_w_q, free_w_d;
  logic                 min_set_q, min_set_d;
  logic [TIME_BITS-1:0] min_busy_q, min_busy_d;
  logic [IDX_W-1:0]     min_idx_q, min_idx_d;
  logic [WEIGHT_W-1:0]  min_w_q, min_w_d;

  always_comb begin
    free_fnd_d = free_fnd_q;
    free_idx_d = free_idx_q;
    free_w_d   = free_w_q;
    min_set_d  = min_set_q;
    min_busy_d = min_busy_q;
    min_idx_d  = min_idx_q;
    min_w_d    = min_w_q;
    if (ctl_i.clear) begin
      free_fnd_d = 1'b0;
      min_set_d  = 1'b0;
    end else if (ctl_i.elem_vld) begin
      // free at the arrival time: lighter weight wins, ties keep lower index
      if (busy_i <= t0_i) begin
        if (!free_fnd_q || (weight_i < free_w_q)) begin
          free_fnd_d = 1'b1;
          free_idx_d = idx_i;
          free_w_d   = weight_i;
        end
      end
      // earliest busy-until, lightest among equal times
      if (!min_set_q || (busy_i < min_busy_q)) begin
        min_set_d  = 1'b1;
        min_busy_d = busy_i;
        min_idx_d  = idx_i;
        min_w_d    = weight_i;
      end else if ((busy_i == min_busy_q) && (weight_i < min_w_q)) begin
        min_idx_d = idx_i;
        min_w_d   = weight_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_fnd_q <= 1'b0;
      min_set_q  <= 1'b0;
    end else begin
      free_fnd_q <= free_fnd_d;
      min_set_q  <= min_set_d;
    end
  end

  always_ff @(posedge clk_i) begin
    free_idx_q <= free_idx_d;
    free_w_q   <= free_w_d;
    min_busy_q <= min_busy_d;
    min_idx_q  <= min_idx_d;
    min_w_q    <= min_w_d;
  end

  assign free_fnd_o = free_fnd_q;
  assign free_idx_o = free_idx_q;
  assign min_busy_o = min_busy_q;
  assign min_idx_o  = min_idx_q;

endmodule

FILE: sv/weighted_server_task_scheduler_top.sv
// top level of the weighted server task scheduler
//
// Input channel (in_valid_i / in_stall_o) carries one beat per item: kind 0
// loads a server weight, kind 1 is a task arrival with its duration. Output
// channel (out_valid_o / out_stall_i) carries one beat per task: the chosen
// server and its start time. Weight loads give no output beat.
// cfg_we_i writes server_count (servers in use, from index 0); write it only
// while the block is idle.
// A weight load is written when it is accepted. A task, once accepted, runs
// through the scan, tail and done states over the servers in use: the
// compare unit looks at one server per cycle, fed from the busy-time and
// weight rams through their single registered read port.
// The result sits in an output register; the next item is accepted while it
// waits. A task that finishes while that register is still stalled waits in
// its last step until the beat is taken.
// Reset clears all weights, busy times, the clock and the task counter (by
// per-server valid bits, no clearing pass) and sets server_count to 16.
module weighted_server_task_scheduler_top #(
  parameter int NUM_SERVERS = wsts_pkg::NUM_SERVERS_DEF,
  parameter int TIME_BITS   = wsts_pkg::TIME_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [wsts_pkg::CFG_W-1:0]    cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [wsts_pkg::KIND_W-1:0]   kind_i,
  input  logic [wsts_pkg::SLOT_W-1:0]   server_slot_i,
  input  logic [wsts_pkg::WEIGHT_W-1:0] weight_i,
  input  logic [wsts_pkg::DUR_W-1:0]    duration_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [wsts_pkg::SRV_W-1:0]    assigned_server_o,
  output logic [wsts_pkg::START_W-1:0]  start_time_o
);
  import wsts_pkg::*;

  localparam int IDX_W = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;
  localparam int SEL_W = ($clog2(NUM_SERVERS + 1) > CFG_W) ? $clog2(NUM_SERVERS + 1) : CFG_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_TAIL = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]           state_q, state_d;
  logic [CFG_W-1:0]     server_count_q;
  logic [TIME_BITS-1:0] cur_time_q, task_num_q;
  logic [TIME_BITS-1:0] t0_q;
  logic [DUR_W-1:0]     dur_q;
  logic [IDX_W-1:0]     last_idx_q, rd_idx_q;
  logic [IDX_W-1:0]     e_idx_q;
  logic                 e_vld_q;
  logic                 e_bvld_q, e_wvld_q;
  logic [NUM_SERVERS-1:0] busy_vld_q, wgt_vld_q;

  logic                 out_valid_q;
  logic [SRV_W-1:0]     out_srv_q;
  logic [START_W-1:0]   out_start_q;

  logic                 in_acc, is_load, is_task, slot_ok;
  logic [SEL_W-1:0]     cnt_ext, num_c, n_act;
  logic [IDX_W-1:0]     last_idx;
  logic [TIME_BITS-1:0] t_arr;

  logic                 wgt_we;
  logic [WEIGHT_W-1:0]  wgt_rdata;
  logic [TIME_BITS-1:0] busy_rdata;
  logic                 busy_we;
  logic [TIME_BITS-1:0] busy_wdata;

  scan_ctl_t            scan_ctl;
  logic [TIME_BITS-1:0] elem_busy;
  logic [WEIGHT_W-1:0]  elem_wgt;
  logic                 free_fnd;
  logic [IDX_W-1:0]     free_idx, min_idx;
  logic [TIME_BITS-1:0] min_busy;

  logic                 done_go;
  logic [TIME_BITS-1:0] t_fin;
  logic [IDX_W-1:0]     best;
  logic [TIME_BITS:0]   end_sum;

  // handshake and item decode
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign is_load    = in_acc && (kind_i == KIND_LOAD);
  assign is_task    = in_acc && (kind_i == KIND_TASK);
  assign slot_ok    = SEL_W'(server_slot_i) < SEL_W'(NUM_SERVERS);
  assign wgt_we     = is_load && slot_ok;

  // servers in use: zero counts as one, clipped to the pool size
  assign cnt_ext  = SEL_W'(server_count_q);
  assign num_c    = SEL_W'(NUM_SERVERS);
  assign n_act    = (cnt_ext == '0) ? SEL_W'(1) : ((cnt_ext > num_c) ? num_c : cnt_ext);
  assign last_idx = IDX_W'(n_act - SEL_W'(1));
  assign t_arr    = (task_num_q > cur_time_q) ? task_num_q : cur_time_q;

  wsts_ram #(
    .WIDTH (WEIGHT_W),
    .DEPTH (NUM_SERVERS)
  ) u_wgt_ram (
    .clk_i   (clk_i),
    .we_i    (wgt_we),
    .waddr_i (IDX_W'(server_slot_i)),
    .wdata_i (weight_i),
    .raddr_i (rd_idx_q),
    .rdata_o (wgt_rdata)
  );

  wsts_ram #(
    .WIDTH (TIME_BITS),
    .DEPTH (NUM_SERVERS)
  ) u_busy_ram (
    .clk_i   (clk_i),
    .we_i    (busy_we),
    .waddr_i (best),
    .wdata_i (busy_wdata),
    .raddr_i (rd_idx_q),
    .rdata_o (busy_rdata)
  );

  // never-written entries read as zero
  assign elem_busy = e_bvld_q ? busy_rdata : '0;
  assign elem_wgt  = e_wvld_q ? wgt_rdata : '0;

  assign scan_ctl.clear    = is_task;
  assign scan_ctl.elem_vld = e_vld_q;

  wsts_scan #(
    .IDX_W     (IDX_W),
    .TIME_BITS (TIME_BITS)
  ) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (scan_ctl),
    .t0_i       (t0_q),
    .idx_i      (e_idx_q),
    .busy_i     (elem_busy),
    .weight_i   (elem_wgt),
    .free_fnd_o (free_fnd),
    .free_idx_o (free_idx),
    .min_busy_o (min_busy),
    .min_idx_o  (min_idx)
  );

  // no free server: jump to the earliest busy-until
  assign t_fin      = free_fnd ? t0_q : min_busy;
  assign best       = free_fnd ? free_idx : min_idx;
  assign end_sum    = {1'b0, t_fin} + {{(TIME_BITS + 1 - DUR_W){1'b0}}, dur_q};
  assign busy_wdata = end_sum[TIME_BITS] ? '1 : end_sum[TIME_BITS-1:0];
  assign done_go    = (state_q == ST_DONE) && !(out_valid_q && out_stall_i);
  assign busy_we    = done_go;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (is_task) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (rd_idx_q == last_idx_q) begin
          state_d = ST_TAIL;
        end
      end
      ST_TAIL: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (done_go) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      server_count_q <= CNT_RESET;
      cur_time_q     <= '0;
      task_num_q     <= '0;
      busy_vld_q     <= '0;
      wgt_vld_q      <= '0;
      e_vld_q        <= 1'b0;
      out_valid_q    <= 1'b0;
      rd_idx_q       <= '0;
    end else begin
      state_q <= state_d;
      e_vld_q <= (state_q == ST_SCAN);
      if (cfg_we_i) begin
        server_count_q <= cfg_wdata_i;
      end
      if (wgt_we) begin
        wgt_vld_q[IDX_W'(server_slot_i)] <= 1'b1;
      end
      if (is_task) begin
        rd_idx_q <= '0;
      end else if (state_q == ST_SCAN) begin
        rd_idx_q <= rd_idx_q + IDX_W'(1);
      end
      if (done_go) begin
        busy_vld_q[best] <= 1'b1;
        cur_time_q       <= t_fin;
        if (task_num_q != '1) begin
          task_num_q <= task_num_q + TIME_BITS'(1);
        end
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_task) begin
      t0_q       <= t_arr;
      dur_q      <= duration_i;
      last_idx_q <= last_idx;
    end
    e_idx_q  <= rd_idx_q;
    e_bvld_q <= busy_vld_q[rd_idx_q];
    e_wvld_q <= wgt_vld_q[rd_idx_q];
    if (done_go) begin
      out_srv_q   <= SRV_W'(best);
      out_start_q <= START_W'(t_fin);
    end
  end

  assign out_valid_o       = out_valid_q;
  assign assigned_server_o = out_srv_q;
  assign start_time_o      = out_start_q;

`include "assert_macros.svh"

  `ASSERT_CLK(a_out_from_done, $rose(out_valid_q) |-> $past(state_q == ST_DONE))
  `ASSERT_CLK(a_scan_in_range, (state_q == ST_SCAN) |-> (rd_idx_q <= last_idx_q))
  `ASSERT_NEVER(a_busy_we_blocked, busy_we && out_valid_q && out_stall_i)
  `ASSERT_CLK(a_tail_after_scan, (state_q == ST_TAIL) |-> $past(state_q == ST_SCAN))

endmodule

FILE: sim/weighted_server_task_scheduler_top_test.sv
// testbench of the weighted server task scheduler, checked against its own scheduling model
module weighted_server_task_scheduler_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import wsts_pkg::*;

  localparam int SERVERS = NUM_SERVERS_DEF;
  localparam logic [START_W-1:0] TIME_TOP = '1;
  localparam int SETTLE_CYCLES = 2 * SERVERS + 8;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 500000;
  localparam int IDLE_PCT = 37;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [SLOT_W-1:0]   slot;
    logic [WEIGHT_W-1:0] weight;
    logic [DUR_W-1:0]    dur;
  } sched_item_t;

  typedef struct packed {
    logic [SRV_W-1:0]   server;
    logic [START_W-1:0] start;
  } assignment_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CFG_W-1:0]    cfg_wdata = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [KIND_W-1:0]   kind = KIND_LOAD;
  logic [SLOT_W-1:0]   server_slot = '0;
  logic [WEIGHT_W-1:0] weight = '0;
  logic [DUR_W-1:0]    duration = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [SRV_W-1:0]    assigned_server;
  logic [START_W-1:0]  start_time;

  // scheduler model state
  logic [WEIGHT_W-1:0] model_weight [SERVERS] = '{default: '0};
  logic [START_W-1:0]  model_busy [SERVERS] = '{default: '0};
  logic [START_W-1:0]  model_clock = '0;
  logic [START_W-1:0]  model_tasks = '0;
  logic [CFG_W-1:0]    model_count = CNT_RESET;

  sched_item_t item_queue[$];
  assignment_t assignments_due[$];
  sched_item_t offered;
  int          mismatches = 0;
  int          cycles = 0;
  bit          no_idle = 1'b0;
  int          holds_asked = 0;
  int          holds_done = 0;
  int          hold_left = 0;

  weighted_server_task_scheduler_top dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .kind_i           (kind),
    .server_slot_i    (server_slot),
    .weight_i         (weight),
    .duration_i       (duration),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .assigned_server_o(assigned_server),
    .start_time_o     (start_time)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // applies one accepted beat to the model
  task automatic schedule_item(input sched_item_t it, output bit produced,
                               output assignment_t res);
    int n;
    int best;
    bit any_free;
    logic [START_W-1:0] t;
    logic [START_W:0] sum;
    produced = 1'b0;
    res = '0;
    if (it.kind == KIND_LOAD) begin
      model_weight[it.slot] = it.weight;
      return;
    end
    n = (model_count == 0) ? 1 : ((model_count > SERVERS) ? SERVERS : int'(model_count));
    t = (model_tasks > model_clock) ? model_tasks : model_clock;
    any_free = 1'b0;
    for (int i = 0; i < n; i++) begin
      if (model_busy[i] <= t) any_free = 1'b1;
    end
    // nobody free: jump to the earliest release
    if (!any_free) begin
      t = model_busy[0];
      for (int i = 1; i < n; i++) begin
        if (model_busy[i] < t) t = model_busy[i];
      end
    end
    best = -1;
    for (int i = 0; i < n; i++) begin
      if (model_busy[i] <= t && (best < 0 || model_weight[i] < model_weight[best])) best = i;
    end
    sum = {1'b0, t} + it.dur;
    model_busy[best] = (sum > {1'b0, TIME_TOP}) ? TIME_TOP : sum[START_W-1:0];
    model_clock = t;
    if (model_tasks != TIME_TOP) model_tasks = model_tasks + 1'b1;
    produced = 1'b1;
    res.server = best[SRV_W-1:0];
    res.start = t;
  endtask

  // input driver
  always @(posedge clk_i) begin
    bit next_valid;
    bit produced;
    assignment_t res;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      next_valid = in_valid;
      if (in_valid && !in_stall) begin
        schedule_item(offered, produced, res);
        if (produced) assignments_due = {assignments_due, res};
        next_valid = 1'b0;
      end
      if (!next_valid && item_queue.size() > 0 &&
          (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
        offered = item_queue.pop_front();
        kind <= offered.kind;
        server_slot <= offered.slot;
        weight <= offered.weight;
        duration <= offered.dur;
        next_valid = 1'b1;
      end
      in_valid <= next_valid;
    end
  end

  // output stall, with one long hold-off
  always @(posedge clk_i) begin
    if (holds_asked != holds_done) begin
      hold_left = HOLD_CYCLES;
      holds_done++;
    end
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !no_idle && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    assignment_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (assignments_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected beat: server %0d start %0d", assigned_server, start_time);
      end else begin
        want = assignments_due.pop_front();
        if (assigned_server !== want.server || start_time !== want.start) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: server exp %0d got %0d, start exp %0d got %0d",
                     want.server, assigned_server, want.start, start_time);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic void add_load(input int slot, input int w);
    sched_item_t it;
    it = '0;
    it.kind = KIND_LOAD;
    it.slot = slot[SLOT_W-1:0];
    it.weight = w[WEIGHT_W-1:0];
    it.dur = DUR_W'($urandom());
    item_queue = {item_queue, it};
  endfunction

  function automatic void add_task(input int d);
    sched_item_t it;
    it = '0;
    it.kind = KIND_TASK;
    it.slot = SLOT_W'($urandom());
    it.weight = WEIGHT_W'($urandom());
    it.dur = d[DUR_W-1:0];
    item_queue = {item_queue, it};
  endfunction

  // often small weights for ties, mostly small durations for contention
  function automatic void add_random(input int count, input int n_srv);
    int w;
    int d;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(99) < 25) begin
        case ($urandom_range(9))
          0:       w = 0;
          1:       w = 65535;
          2, 3, 4: w = $urandom_range(3);
          default: w = $urandom_range(65535);
        endcase
        add_load($urandom_range(SERVERS - 1), w);
      end else begin
        case ($urandom_range(9))
          0:       d = 0;
          1:       d = 65535;
          2:       d = $urandom_range(65535);
          default: d = $urandom_range(3 * n_srv + 2);
        endcase
        add_task(d);
      end
    end
  endfunction

  // sender pause: nothing offered until every result is back
  task automatic await_drain();
    do @(negedge clk_i);
    while (item_queue.size() != 0 || in_valid || assignments_due.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_count(input logic [CFG_W-1:0] c);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_wdata <= c;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    model_count = c;
    @(negedge clk_i);
  endtask

  initial begin
    int phase_count [8];
    phase_count = '{1, 0, 16, 31, 4, 2, 9, 16};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset count, extreme weights and durations, weight ties
    add_load(0, 65535);
    add_load(15, 0);
    add_load(7, 16'hAAAA);
    add_task(0);
    add_task(65535);
    add_task(1);
    add_task(16'h5555);
    add_load(1, 65535);
    add_task(0);
    await_drain();

    // two servers: all busy forces a time jump, loads to busy and unused servers
    set_count(5'd2);
    add_task(65535);
    add_task(65535);
    add_task(3);
    add_load(1, 0);
    add_load(0, 1);
    add_task(0);
    add_task(0);
    add_load(9, 0);
    add_task(7);
    add_task(65535);
    add_task(0);
    await_drain();

    for (int p = 0; p < 8; p++) begin
      set_count(phase_count[p][CFG_W-1:0]);
      no_idle = (p == 5);
      add_random(103, (phase_count[p] > SERVERS || phase_count[p] == 0) ?
                      SERVERS : phase_count[p]);
      if (p == 3) holds_asked++;
      await_drain();
    end

    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+sv
sv/wsts_pkg.sv
sv/wsts_ram.sv
sv/wsts_scan.sv
sv/weighted_server_task_scheduler_top.sv
sim/weighted_server_task_scheduler_top_test.sv
